// File: rtl/core/kfsi_pkg.sv
package kfsi_pkg;

    localparam int MaxTracks = 8;
    localparam int MaxKeys   = 16;
    localparam int TrW       = 3;
    localparam int KeyW      = 4;
    localparam int CntW      = 5;
    localparam int AddrW     = TrW + KeyW;
    localparam int NumVals   = 5;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_HEADER = 2'd1;
    localparam logic [1:0] REQ_APPEND = 2'd2;
    localparam logic [1:0] REQ_EVAL   = 2'd3;

    // one queued command from the front end
    typedef struct packed {
        logic [1:0]        req;
        logic [TrW-1:0]    track;
        logic [7:0]        kind;
        logic [7:0]        number;
        logic signed [31:0] t;
        logic [NumVals-1:0][31:0] vals;
    } cmd_t;

    typedef struct packed {
        logic               has_state;
        logic [7:0]         kind;
        logic [7:0]         number;
        logic [NumVals-1:0][31:0] vals;
        logic               last;
    } res_t;

endpackage

// File: rtl/core/kfsi_front.sv
// Input register and command queue (depth 2).
module kfsi_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  kfsi_pkg::cmd_t in_cmd,
    output logic           q_valid,
    input  logic           q_ready,
    output kfsi_pkg::cmd_t q_cmd
);
    kfsi_pkg::cmd_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_cmd;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> cnt_reg != 2'd0) else $error("pop from empty queue");
endmodule

// File: rtl/core/kfsi_div.sv
// Radix-2 restoring divider: quo = floor(num*65536/den), num < den, 16 steps.
module kfsi_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [32:0] num,
    input  logic [32:0] den,
    output logic        done,
    output logic [15:0] quo
);
    logic [33:0] rem_reg;
    logic [32:0] den_reg;
    logic [15:0] quo_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [33:0] sh;
    logic        ge;

    assign sh   = {rem_reg[32:0], 1'b0};
    assign ge   = sh >= {1'b0, den_reg};
    assign quo  = quo_reg;
    assign done = busy_reg && (cnt_reg == 5'd16);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd0;
            rem_reg  <= {1'b0, num};
            den_reg  <= den;
        end else if (busy_reg) begin
            if (cnt_reg == 5'd16) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 5'd1;
                rem_reg <= ge ? sh - {1'b0, den_reg} : sh;
                quo_reg <= {quo_reg[14:0], ge};
            end
        end
    end
endmodule

// File: rtl/core/kfsi_back.sv
// Executes commands: track table, key memory, per-track evaluate sequencer.
module kfsi_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  kfsi_pkg::cmd_t q_cmd,
    output logic           r_valid,
    input  logic           r_ready,
    output kfsi_pkg::res_t r_res
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_NEXT  = 4'd1;
    localparam logic [3:0] ST_RD0   = 4'd2;
    localparam logic [3:0] ST_CHK0  = 4'd3;
    localparam logic [3:0] ST_SCAN  = 4'd4;
    localparam logic [3:0] ST_SCHK  = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_SM1   = 4'd7;
    localparam logic [3:0] ST_SM2   = 4'd8;
    localparam logic [3:0] ST_VRD   = 4'd9;
    localparam logic [3:0] ST_LERP  = 4'd10;
    localparam logic [3:0] ST_MUL   = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;
    localparam logic [3:0] ST_EMPTY = 4'd13;
    localparam int NV = kfsi_pkg::NumVals;

    logic [kfsi_pkg::MaxTracks-1:0] def_reg;
    logic [7:0] kind_reg [kfsi_pkg::MaxTracks];
    logic [7:0] num_reg  [kfsi_pkg::MaxTracks];
    logic [kfsi_pkg::CntW-1:0] kcnt_reg [kfsi_pkg::MaxTracks];
    logic [kfsi_pkg::MaxTracks-1:0] lastt_ok_reg;
    logic signed [31:0] lastt_reg [kfsi_pkg::MaxTracks];

    // key memory: time plus five values, one write and one read port
    logic [6*32-1:0] kmem [kfsi_pkg::MaxTracks*kfsi_pkg::MaxKeys];
    logic [6*32-1:0] rd_reg;
    logic [kfsi_pkg::AddrW-1:0] raddr;
    logic rd_en;

    logic [3:0] st_reg;
    logic signed [31:0] t_reg;
    logic [kfsi_pkg::TrW:0] tr_reg;
    logic [kfsi_pkg::KeyW-1:0] i_reg;
    logic [kfsi_pkg::KeyW-1:0] ia_reg;
    logic signed [31:0] ta_reg;
    logic [15:0] s_reg;
    logic [31:0] a2_reg;
    logic [NV-1:0][31:0] va_reg;
    logic [2:0] v_reg;
    logic [kfsi_pkg::NumVals-1:0][31:0] acc_reg;
    logic found_reg;
    logic r_valid_reg;
    kfsi_pkg::res_t r_reg;

    logic [kfsi_pkg::TrW-1:0] tr;
    logic tr_live;
    logic [kfsi_pkg::CntW-1:0] n;
    logic signed [31:0] rd_t;
    logic div_start, div_done;
    logic [15:0] alpha;
    logic [32:0] div_num, div_den;
    logic any_after;
    logic signed [31:0] cur_va, cur_vb;
    logic signed [32:0] diff;
    logic signed [50:0] prod;
    logic [2:0] vidx;
    logic r_load;

    function automatic logic [kfsi_pkg::KeyW-1:0] KeyW1(input logic [kfsi_pkg::CntW-1:0] c);
        logic [kfsi_pkg::CntW-1:0] m;
        m = c - 1'b1;
        return m[kfsi_pkg::KeyW-1:0];
    endfunction

    assign tr      = tr_reg[kfsi_pkg::TrW-1:0];
    assign n       = kcnt_reg[tr];
    assign tr_live = def_reg[tr] && (n != '0);
    assign rd_t    = $signed(rd_reg[31:0]);
    assign q_ready = (st_reg == ST_IDLE);
    assign r_valid = r_valid_reg;
    assign r_res   = r_reg;
    assign vidx    = v_reg;
    assign r_load  = ((st_reg == ST_OUT) || (st_reg == ST_EMPTY)) && (!r_valid_reg || r_ready);

    // further non-empty track beyond the current one
    always_comb begin
        any_after = 1'b0;
        for (int k = 0; k < kfsi_pkg::MaxTracks; k++) begin
            if (k > int'(tr) && def_reg[k] && kcnt_reg[k] != '0) any_after = 1'b1;
        end
    end

    // key b equals key a on a clamp (s is zero), so no entry past the count is read
    always_comb begin
        rd_en = 1'b0;
        raddr = {tr, i_reg};
        unique case (st_reg)
            ST_RD0:  begin rd_en = 1'b1; raddr = {tr, {kfsi_pkg::KeyW{1'b0}}}; end
            ST_SCAN: begin rd_en = 1'b1; raddr = {tr, i_reg}; end
            ST_VRD:  begin rd_en = 1'b1; raddr = {tr, ia_reg}; end
            ST_LERP: begin
                rd_en = 1'b1;
                raddr = {tr, (s_reg == '0) ? ia_reg : ia_reg + 1'b1};
            end
            default: ;
        endcase
    end

    assign div_num   = 33'($signed({t_reg[31], t_reg}) - $signed({ta_reg[31], ta_reg}));
    assign div_den   = 33'($signed({rd_t[31], rd_t}) - $signed({ta_reg[31], ta_reg}));
    assign div_start = (st_reg == ST_SCHK) && (t_reg < rd_t);

    kfsi_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(div_den), .done(div_done), .quo(alpha)
    );

    assign cur_va = $signed(va_reg[vidx]);
    assign cur_vb = $signed(rd_reg[32*(vidx+1) +: 32]);
    assign diff   = $signed({cur_vb[31], cur_vb}) - $signed({cur_va[31], cur_va});
    assign prod   = $signed({1'b0, s_reg}) * diff;

    always_ff @(posedge aclk) begin
        if (rd_en) rd_reg <= kmem[raddr];
        if (st_reg == ST_IDLE && q_valid && q_cmd.req == kfsi_pkg::REQ_APPEND
            && def_reg[q_cmd.track] && kcnt_reg[q_cmd.track] < kfsi_pkg::CntW'(kfsi_pkg::MaxKeys)
            && (!lastt_ok_reg[q_cmd.track] || q_cmd.t >= lastt_reg[q_cmd.track])) begin
            kmem[{q_cmd.track, kcnt_reg[q_cmd.track][kfsi_pkg::KeyW-1:0]}]
                <= {q_cmd.vals, q_cmd.t};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            def_reg      <= '0;
            lastt_ok_reg <= '0;
            r_valid_reg  <= 1'b0;
            for (int k = 0; k < kfsi_pkg::MaxTracks; k++) begin
                kind_reg[k] <= '0;
                num_reg[k]  <= '0;
                kcnt_reg[k] <= '0;
            end
        end else begin
            if (r_load) r_valid_reg <= 1'b1;
            else if (r_valid_reg && r_ready) r_valid_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE: if (q_valid) begin
                    unique case (q_cmd.req)
                        kfsi_pkg::REQ_CLEAR: begin
                            def_reg      <= '0;
                            lastt_ok_reg <= '0;
                            for (int k = 0; k < kfsi_pkg::MaxTracks; k++) begin
                                kind_reg[k] <= '0;
                                num_reg[k]  <= '0;
                                kcnt_reg[k] <= '0;
                            end
                        end
                        kfsi_pkg::REQ_HEADER: begin
                            def_reg[q_cmd.track]  <= 1'b1;
                            kind_reg[q_cmd.track] <= q_cmd.kind;
                            num_reg[q_cmd.track]  <= q_cmd.number;
                        end
                        kfsi_pkg::REQ_APPEND: begin
                            if (def_reg[q_cmd.track]
                                && kcnt_reg[q_cmd.track] < kfsi_pkg::CntW'(kfsi_pkg::MaxKeys)
                                && (!lastt_ok_reg[q_cmd.track]
                                    || q_cmd.t >= lastt_reg[q_cmd.track])) begin
                                kcnt_reg[q_cmd.track]     <= kcnt_reg[q_cmd.track] + 1'b1;
                                lastt_reg[q_cmd.track]    <= q_cmd.t;
                                lastt_ok_reg[q_cmd.track] <= 1'b1;
                            end
                        end
                        kfsi_pkg::REQ_EVAL: begin
                            t_reg     <= q_cmd.t;
                            tr_reg    <= '0;
                            found_reg <= 1'b0;
                            st_reg    <= ST_NEXT;
                        end
                    endcase
                end
                ST_NEXT: begin
                    if (tr_reg == (kfsi_pkg::TrW+1)'(kfsi_pkg::MaxTracks)) begin
                        st_reg <= found_reg ? ST_IDLE : ST_EMPTY;
                    end else if (tr_live) begin
                        st_reg <= ST_RD0;
                    end else begin
                        tr_reg <= tr_reg + 1'b1;
                    end
                end
                ST_RD0: st_reg <= ST_CHK0;
                ST_CHK0: begin
                    s_reg <= '0;
                    va_reg <= rd_reg[6*32-1:32];
                    if (t_reg <= rd_t) begin
                        ia_reg <= '0;
                        st_reg <= ST_VRD;
                    end else if (t_reg >= lastt_reg[tr]) begin
                        ia_reg <= KeyW1(n);
                        st_reg <= ST_VRD;
                    end else begin
                        ta_reg <= rd_t;
                        ia_reg <= '0;
                        i_reg  <= 4'd1;
                        st_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: st_reg <= ST_SCHK;
                ST_SCHK: begin
                    if (t_reg < rd_t) begin
                        st_reg <= ST_DIV;
                    end else begin
                        ta_reg <= rd_t;
                        ia_reg <= i_reg;
                        i_reg  <= i_reg + 1'b1;
                        st_reg <= ST_SCAN;
                    end
                end
                ST_DIV: if (div_done) begin
                    a2_reg <= 32'(alpha) * 32'(alpha);
                    s_reg  <= alpha;
                    st_reg <= ST_SM1;
                end
                ST_SM1: begin
                    s_reg  <= 16'((64'(a2_reg) * (18'd196608 - 18'({s_reg, 1'b0}))) >> 32);
                    st_reg <= ST_SM2;
                end
                ST_SM2: st_reg <= ST_VRD;
                ST_VRD: begin
                    v_reg  <= '0;
                    st_reg <= ST_LERP;
                end
                ST_LERP: begin
                    va_reg <= rd_reg[6*32-1:32];
                    st_reg <= ST_MUL;
                    v_reg  <= '0;
                end
                ST_MUL: begin
                    // rd_reg now holds key b; one value per cycle
                    acc_reg[vidx] <= cur_va + 32'(prod >>> 16);
                    if (vidx == 3'(NV-1)) st_reg <= ST_OUT;
                    else v_reg <= v_reg + 1'b1;
                end
                ST_OUT: if (r_load) begin
                    r_reg.has_state <= 1'b1;
                    r_reg.kind      <= kind_reg[tr];
                    r_reg.number    <= num_reg[tr];
                    r_reg.vals      <= acc_reg;
                    r_reg.last      <= !any_after;
                    found_reg       <= 1'b1;
                    tr_reg          <= tr_reg + 1'b1;
                    st_reg          <= ST_NEXT;
                end
                ST_EMPTY: if (r_load) begin
                    r_reg  <= '{last: 1'b1, default: '0};
                    st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_OUT && r_valid_reg && !r_ready |=> st_reg == ST_OUT)
        else $error("result overwritten while stalled");
    a_busy_nready: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg != ST_IDLE |-> !q_ready) else $error("accepted while busy");
    a_div_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> div_den != '0) else $error("zero divisor");
endmodule

// File: rtl/core/keyframe_smoothstep_interpolator_top.sv
// Keyframe smoothstep interpolator.
// Input stream s_*: one request per item. tuser = req_type, tdata holds the
// track, header and key fields. Clear, header and append give no result.
// Evaluate gives one result per defined non-empty track, in track order,
// last on the final one; with no such track one item with has_state 0.
// Output stream m_*: tuser = has_state, tlast = last, tdata the state.
// Evaluate, per defined non-empty track: read the first key; when t clamps to
// an end key, go straight to the value read; inside a segment, scan the keys,
// then wait on the alpha divider (radix-2, one bit a cycle), apply smoothstep,
// read both bracketing keys and blend the values. Tracks that are undefined or
// empty are skipped; other requests are executed directly in the idle state.
// A two-entry queue decouples input from the sequencer, and a result
// register decouples it from the receiver; a stalled receiver holds the
// sequencer at its result step and backs up the input queue.
// Reset (aresetn low, synchronous) clears all tracks and both handshakes;
// key memory needs no clearing, only entries below a track count are read.
module keyframe_smoothstep_interpolator_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // track_sel[2:0], entity_kind[10:3], entity_number[18:11], time_value[50:19],
    // pos_x[82:51], pos_y[114:83], angle[146:115], size_w[178:147],
    // size_h[210:179], zero pad
    input  logic [215:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_kind[7:0], out_number[15:8], out_x[47:16], out_y[79:48],
    // out_angle[111:80], out_w[143:112], out_h[175:144]
    output logic [175:0] m_tdata,
    // has_state
    output logic         m_tuser,
    output logic         m_tlast
);
    kfsi_pkg::cmd_t in_cmd, q_cmd;
    kfsi_pkg::res_t res;
    logic q_valid, q_ready;

    assign in_cmd.req    = s_tuser;
    assign in_cmd.track  = s_tdata[2:0];
    assign in_cmd.kind   = s_tdata[10:3];
    assign in_cmd.number = s_tdata[18:11];
    assign in_cmd.t      = s_tdata[50:19];
    assign in_cmd.vals   = {s_tdata[210:179], s_tdata[178:147], s_tdata[146:115],
                            s_tdata[114:83], s_tdata[82:51]};

    kfsi_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    kfsi_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_cmd(q_cmd), .r_valid(m_tvalid), .r_ready(m_tready), .r_res(res)
    );

    assign m_tuser = res.has_state;
    assign m_tlast = res.last;
    assign m_tdata = {res.vals, res.number, res.kind};
endmodule
